FILE: src/mies_pkg.sv
// Shared types, opcodes and constants for the MIPS integer execute subset.
`timescale 1ns / 1ps
`default_nettype none
package mies_pkg;
   localparam int MemBytes = 4096;
   localparam int MemWords = (MemBytes + 3) / 4;
   localparam int MemAw = (MemWords > 1) ? $clog2(MemWords) : 1;
   localparam logic [31:0] MemBase = 32'h8000_0000;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_UNKNOWN = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_XORI    = 6'h0E;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2B;

   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_SRA  = 6'h03;
   localparam logic [5:0] FN_SLLV = 6'h04;
   localparam logic [5:0] FN_SRLV = 6'h06;
   localparam logic [5:0] FN_SRAV = 6'h07;
   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_XOR  = 6'h26;
   localparam logic [5:0] FN_NOR  = 6'h27;
   localparam logic [5:0] FN_SLT  = 6'h2A;
   localparam logic [5:0] FN_SLTU = 6'h2B;

   typedef enum logic [1:0] {
      MEM_NONE  = 2'd0,
      MEM_LOAD  = 2'd1,
      MEM_STORE = 2'd2
   } mem_kind_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  reg_written;
      logic [63:0] reg_value;
      logic [31:0] mem_address;
      logic        mem_stored;
   } rsp_type;

   function automatic logic [63:0] sext32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction
endpackage
`default_nettype wire

FILE: src/mies_if.sv
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
`default_nettype none
interface mies_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction;
   modport source (output valid, output instruction, input ready);
   modport sink (input valid, input instruction, output ready);
endinterface

interface mies_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [4:0]  reg_written;
   logic [63:0] reg_value;
   logic [31:0] mem_address;
   logic        mem_stored;
   modport source (output valid, output status, output reg_written, output reg_value,
                   output mem_address, output mem_stored, input ready);
   modport sink (input valid, input status, input reg_written, input reg_value,
                 input mem_address, input mem_stored, output ready);
endinterface
`default_nettype wire

FILE: src/mips_integer_execute_subset_top.sv
// Top level: MIPS integer/load/store execute with register file and data memory.
// Response is registered: a request passes the stage 1 registers, then the output register.
// Throughput: one request per cycle while rsp.ready keeps the output moving; the memory word
// is read as the request is accepted and written back as it moves to the output, with
// forwarding into register and memory reads.
// Reset: synchronous; a clearing pass over all MemWords (1024) words zeroes the data
// memory with req.ready low; the register file resets through per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
module mips_integer_execute_subset_top (
   input wire logic  clock,
   input wire logic  reset,
   mies_req_if.sink  req,
   mies_rsp_if.source rsp
);
   // ---------------- clearing pass ----------------
   logic                    clr_busy_ff, clr_busy_in;
   logic [mies_pkg::MemAw:0] clr_cnt_ff, clr_cnt_in;

   // ---------------- register file: 32 x 64, reg valid bits ----------------
   logic [63:0] rf_mem [32];
   logic [31:0] rf_vld_ff;

   // ---------------- data memory ----------------
   logic [31:0] dmem [mies_pkg::MemWords];
   logic [31:0] dm_rdata_ff;

   // stage 1 registers (after accept): instruction, operands and word index
   logic        s1_vld_ff;
   logic [31:0] s1_ins_ff;
   logic [63:0] s1_a_ff, s1_b_ff;
   logic [mies_pkg::MemAw-1:0] s1_wi_ff;

   // stage 2: output register
   logic                 out_vld_ff;
   mies_pkg::rsp_type    out_ff;

   // write-back from stage 1 execution (happens when s1 advances)
   logic        adv;
   logic        rf_we;
   logic [4:0]  rf_wa;
   logic [63:0] rf_wd;
   logic        dm_we;
   logic [mies_pkg::MemAw-1:0] dm_wa;
   logic [31:0] dm_wd;
   mies_pkg::rsp_type s1_rsp;

   // last memory write, kept for forwarding into the word read of the next request
   logic [mies_pkg::MemAw-1:0] dm_last_wi_ff;
   logic [31:0]                dm_last_wd_ff;

   assign adv = s1_vld_ff && (!out_vld_ff || rsp.ready);
   assign req.ready = !clr_busy_ff && (!s1_vld_ff || adv);

   logic acc;
   assign acc = req.valid && req.ready;

   // ---------------- stage 0: operand read with forwarding ----------------
   logic [4:0]  rs0, rt0;
   logic [63:0] a0, b0, ea0;
   logic [31:0] off0;
   logic [mies_pkg::MemAw-1:0] wi0;
   always_comb begin
      rs0 = req.instruction[25:21];
      rt0 = req.instruction[20:16];
      a0 = rf_vld_ff[rs0] ? rf_mem[rs0] : 64'd0;
      b0 = rf_vld_ff[rt0] ? rf_mem[rt0] : 64'd0;
      if (rf_we && rf_wa == rs0) a0 = rf_wd;
      if (rf_we && rf_wa == rt0) b0 = rf_wd;
      ea0 = a0 + {{48{req.instruction[15]}}, req.instruction[15:0]};
      off0 = ea0[31:0] - mies_pkg::MemBase;
      wi0 = off0[mies_pkg::MemAw+1:2];
   end

   // memory read (registered, taken with the request so it holds while stalled)
   // plus clearing pass writes and store writes
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         dmem[clr_cnt_ff[mies_pkg::MemAw-1:0]] <= 32'd0;
      end else if (dm_we) begin
         dmem[dm_wa] <= dm_wd;
      end
      if (acc) dm_rdata_ff <= dmem[wi0];
   end

   // ---------------- stage 1 execute ----------------
   logic [31:0] word1;
   always_comb begin
      logic [5:0]  op, fn;
      logic [4:0]  rt, rd, sa, sh;
      logic [63:0] a, b, imm, zimm, val;
      logic [31:0] addr, off, nw;
      logic [4:0]  bsh, hsh;
      logic        wr, ok;
      logic [4:0]  dest;
      logic [1:0]  st;
      logic        stored;
      op = s1_ins_ff[31:26];
      fn = s1_ins_ff[5:0];
      rt = s1_ins_ff[20:16];
      rd = s1_ins_ff[15:11];
      sa = s1_ins_ff[10:6];
      a = s1_a_ff;
      b = s1_b_ff;
      sh = a[4:0];
      imm = {{48{s1_ins_ff[15]}}, s1_ins_ff[15:0]};
      zimm = {48'd0, s1_ins_ff[15:0]};
      // forwarded memory word: the store held in the output register to the same word wins
      word1 = (out_vld_ff && out_ff.mem_stored && dm_last_wi_ff == s1_wi_ff) ?
              dm_last_wd_ff : dm_rdata_ff;
      val = 64'd0; wr = 1'b0; dest = 5'd0; st = mies_pkg::STATUS_OK;
      stored = 1'b0; addr = 32'd0; nw = word1;
      addr = 32'd0; off = 32'd0; ok = 1'b0;
      bsh = 5'd0; hsh = 5'd0;
      if (op == mies_pkg::OP_SPECIAL) begin
         dest = rd; wr = 1'b1;
         unique case (fn)
            mies_pkg::FN_SLL:  val = mies_pkg::sext32(b[31:0] << sa);
            mies_pkg::FN_SRL:  val = mies_pkg::sext32(b[31:0] >> sa);
            mies_pkg::FN_SRA:  val = mies_pkg::sext32(32'($signed(b[31:0]) >>> sa));
            mies_pkg::FN_SLLV: val = mies_pkg::sext32(b[31:0] << sh);
            mies_pkg::FN_SRLV: val = mies_pkg::sext32(b[31:0] >> sh);
            mies_pkg::FN_SRAV: val = mies_pkg::sext32(32'($signed(b[31:0]) >>> sh));
            mies_pkg::FN_ADD, mies_pkg::FN_ADDU:
               val = mies_pkg::sext32(a[31:0] + b[31:0]);
            mies_pkg::FN_SUB, mies_pkg::FN_SUBU:
               val = mies_pkg::sext32(a[31:0] - b[31:0]);
            mies_pkg::FN_AND:  val = a & b;
            mies_pkg::FN_OR:   val = a | b;
            mies_pkg::FN_XOR:  val = a ^ b;
            mies_pkg::FN_NOR:  val = ~(a | b);
            mies_pkg::FN_SLT:  val = {63'd0, $signed(a) < $signed(b)};
            mies_pkg::FN_SLTU: val = {63'd0, a < b};
            default: begin
               st = mies_pkg::STATUS_UNKNOWN; wr = 1'b0;
            end
         endcase
      end else if (op[5:3] == 3'b001) begin
         dest = rt; wr = 1'b1;
         unique case (op)
            mies_pkg::OP_ADDI, mies_pkg::OP_ADDIU:
               val = mies_pkg::sext32(a[31:0] + imm[31:0]);
            mies_pkg::OP_SLTI:  val = {63'd0, $signed(a) < $signed(imm)};
            mies_pkg::OP_SLTIU: val = {63'd0, a < imm};
            mies_pkg::OP_ANDI:  val = a & zimm;
            mies_pkg::OP_ORI:   val = a | zimm;
            mies_pkg::OP_XORI:  val = a ^ zimm;
            default:            val = mies_pkg::sext32({s1_ins_ff[15:0], 16'd0});
         endcase
      end else if (op == mies_pkg::OP_LB || op == mies_pkg::OP_LH ||
                   op == mies_pkg::OP_LW || op == mies_pkg::OP_LBU ||
                   op == mies_pkg::OP_LHU || op == mies_pkg::OP_SB ||
                   op == mies_pkg::OP_SH || op == mies_pkg::OP_SW) begin
         addr = a[31:0] + imm[31:0];
         off = addr - mies_pkg::MemBase;
         ok = off < 32'(mies_pkg::MemBytes);
         bsh = {~off[1:0], 3'd0};
         hsh = {~off[1], 4'd0};
         if (!ok) begin
            st = mies_pkg::STATUS_RANGE;
         end else begin
            unique case (op)
               mies_pkg::OP_LB: begin
                  dest = rt; wr = 1'b1;
                  val = {{56{word1[bsh+7]}}, 8'(word1 >> bsh)};
               end
               mies_pkg::OP_LH: begin
                  dest = rt; wr = 1'b1;
                  val = {{48{word1[hsh+15]}}, 16'(word1 >> hsh)};
               end
               mies_pkg::OP_LW: begin
                  dest = rt; wr = 1'b1; val = mies_pkg::sext32(word1);
               end
               mies_pkg::OP_LBU: begin
                  dest = rt; wr = 1'b1; val = {56'd0, 8'(word1 >> bsh)};
               end
               mies_pkg::OP_LHU: begin
                  dest = rt; wr = 1'b1; val = {48'd0, 16'(word1 >> hsh)};
               end
               mies_pkg::OP_SB: begin
                  stored = 1'b1;
                  nw = (word1 & ~(32'hFF << bsh)) | ({24'd0, b[7:0]} << bsh);
               end
               mies_pkg::OP_SH: begin
                  stored = 1'b1;
                  nw = (word1 & ~(32'hFFFF << hsh)) | ({16'd0, b[15:0]} << hsh);
               end
               default: begin
                  stored = 1'b1; nw = b[31:0];
               end
            endcase
         end
      end else begin
         st = mies_pkg::STATUS_UNKNOWN;
      end
      if (!wr || dest == 5'd0) begin
         dest = 5'd0; val = 64'd0;
      end
      s1_rsp.status = st;
      s1_rsp.reg_written = dest;
      s1_rsp.reg_value = val;
      s1_rsp.mem_address = addr;
      s1_rsp.mem_stored = stored;
      dm_wd = nw;
   end

   assign rf_we = adv && s1_rsp.reg_written != 5'd0;
   assign rf_wa = s1_rsp.reg_written;
   assign rf_wd = s1_rsp.reg_value;
   assign dm_we = adv && s1_rsp.mem_stored;
   assign dm_wa = s1_wi_ff;

   // register file writes (no reset on storage; valid bits mask unwritten entries)
   always_ff @(posedge clock) begin
      if (rf_we) rf_mem[rf_wa] <= rf_wd;
   end

   // pipeline control
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == (mies_pkg::MemAw+1)'(mies_pkg::MemWords - 1)) clr_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff <= '0;
         rf_vld_ff <= '0;
         s1_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff <= clr_cnt_in;
         if (rf_we) rf_vld_ff[rf_wa] <= 1'b1;
         if (acc) s1_vld_ff <= 1'b1;
         else if (adv) s1_vld_ff <= 1'b0;
         if (adv) out_vld_ff <= 1'b1;
         else if (rsp.ready) out_vld_ff <= 1'b0;
      end
   end

   // payload registers; the last store word is kept for the next word read.
   // A store moves from stage 1 to output as the next request enters stage 1,
   // whose memory read was issued in the same cycle as that write: forward it.
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_ins_ff <= req.instruction;
         s1_a_ff <= a0;
         s1_b_ff <= b0;
         s1_wi_ff <= wi0;
      end
      if (adv) begin
         out_ff <= s1_rsp;
         dm_last_wi_ff <= dm_wa;
         dm_last_wd_ff <= dm_wd;
      end
   end

   assign rsp.valid = out_vld_ff;
   assign rsp.status = out_ff.status;
   assign rsp.reg_written = out_ff.reg_written;
   assign rsp.reg_value = out_ff.reg_value;
   assign rsp.mem_address = out_ff.mem_address;
   assign rsp.mem_stored = out_ff.mem_stored;

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req.ready) else $error("request taken during memory clear");
   a_r0_never: assert property (@(posedge clock) disable iff (reset)
      !(rf_we && rf_wa == 5'd0)) else $error("register zero written");
   a_unknown_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == mies_pkg::STATUS_UNKNOWN) |->
      (rsp.reg_written == 5'd0 && !rsp.mem_stored)) else $error("unknown op wrote state");
   a_out_held: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp.ready) |=> out_vld_ff) else $error("response dropped");
endmodule
`default_nettype wire
